>>> sv/assert_macros.svh
// assertion macros shared by the supervisor rtl
// no dependencies; checks compile away when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CHK_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CHK_IMPL(name, clk, rst, ante, cons)
`define CHK_NEXT(name, clk, rst, ante, cons)
`endif
`endif

>>> sv/mtws_pkg.sv
// types, codes and reset constants of the watchdog supervisor
// no dependencies
package mtws_pkg;

   localparam int MAX_REPORTERS = 31;
   localparam int CNT_W         = 16;
   localparam int REQ_W         = 5;

   localparam logic [REQ_W-1:0] REQUIRED_RESET = 5'd31;
   localparam logic [CNT_W-1:0] INTERVAL_RESET = 16'd10;
   localparam logic             ENABLE_RESET   = 1'b1;

   typedef enum logic [2:0] {
      OP_TICK       = 3'd0,
      OP_REPORT     = 3'd1,
      OP_REPORT_ALL = 3'd2,
      OP_INIT       = 3'd3,
      OP_FORCE_INT  = 3'd4,
      OP_FORCE_EXT  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_REQUIRED = 2'd0,
      CSR_INTERVAL = 2'd1,
      CSR_ENABLE   = 2'd2
   } csr_index_type;

   typedef logic [MAX_REPORTERS-1:0] mask_type;

   function automatic mask_type required_mask(input logic [REQ_W-1:0] count);
      logic [REQ_W-1:0]     r;
      logic [MAX_REPORTERS:0] bit_one;
      begin
         r = count;
         if (32'(r) > 32'(MAX_REPORTERS)) begin
            r = REQ_W'(MAX_REPORTERS);
         end
         bit_one = (MAX_REPORTERS+1)'(1) << r;
         required_mask = mask_type'(bit_one - (MAX_REPORTERS+1)'(1));
      end
   endfunction

endpackage

>>> sv/multi_task_watchdog_supervisor_top.sv
// response: registered, and presented in the cycle after its request is accepted
// throughput: one request per cycle; the single response register decouples the
// two sides and the next request is taken whenever that register drains
// reset: synchronous active high; clears mask, flags and counter to their reset
// values and the config registers to 31, 10 and 1; no clearing pass
module multi_task_watchdog_supervisor_top
   import mtws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // opcode[2:0], reporter_id[7:3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // internal_feed[0], external_level[1],
                                    // timeout_suspect[2], saved_reports[33:3],
                                    // all_reported[34], zero[39:35]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
`include "assert_macros.svh"

   logic [REQ_W-1:0] required_ff;
   logic [CNT_W-1:0] interval_ff;
   logic             enable_ff;

   mask_type         mask_ff, mask_in;
   logic [CNT_W-1:0] countdown_ff, countdown_in;
   logic             phase_ff, phase_in;
   logic             ext_allowed_ff, ext_allowed_in;
   logic             int_blocked_ff, int_blocked_in;
   mask_type         captured_ff, captured_in;
   logic             suspect_ff, suspect_in;

   logic             rsp_valid_ff;
   logic [39:0]      rsp_data_ff, rsp_data_in;

   logic             req_acc;
   logic             csr_wr;
   csr_index_type    csr_idx;
   opcode_type       op;
   logic [4:0]       rep_id;
   mask_type         req_mask;
   logic             fed;
   logic             all_rep;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         required_ff <= REQUIRED_RESET;
         interval_ff <= INTERVAL_RESET;
         enable_ff   <= ENABLE_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_REQUIRED: required_ff <= csr_pwdata[REQ_W-1:0];
            CSR_INTERVAL: interval_ff <= csr_pwdata[CNT_W-1:0];
            CSR_ENABLE:   enable_ff   <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_REQUIRED: csr_prdata = {{(32-REQ_W){1'b0}}, required_ff};
         CSR_INTERVAL: csr_prdata = {{(32-CNT_W){1'b0}}, interval_ff};
         CSR_ENABLE:   csr_prdata = {31'd0, enable_ff};
         default:      csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_acc    = req_tvalid && req_tready;
   assign op         = opcode_type'(req_tdata[2:0]);
   assign rep_id     = req_tdata[7:3];
   assign req_mask   = required_mask(required_ff);

   always_comb begin
      mask_in        = mask_ff;
      countdown_in   = countdown_ff;
      phase_in       = phase_ff;
      ext_allowed_in = ext_allowed_ff;
      int_blocked_in = int_blocked_ff;
      captured_in    = captured_ff;
      suspect_in     = suspect_ff;
      fed            = 1'b0;
      unique case (op)
         OP_TICK: begin
            if (!enable_ff || countdown_ff != '0) begin
               fed      = !int_blocked_ff;
               phase_in = phase_ff ^ ext_allowed_ff;
               if (enable_ff) begin
                  countdown_in = countdown_ff - CNT_W'(1);
                  suspect_in   = 1'b0;
               end
            end else begin
               captured_in = mask_ff;
               suspect_in  = 1'b1;
               if ((mask_ff & req_mask) == req_mask) begin
                  fed          = !int_blocked_ff;
                  phase_in     = phase_ff ^ ext_allowed_ff;
                  mask_in      = '0;
                  countdown_in = interval_ff;
               end
            end
         end
         OP_REPORT: begin
            if (rep_id != 5'd0 && 32'(rep_id) <= 32'(MAX_REPORTERS)) begin
               mask_in = mask_ff | (mask_type'(1) << (rep_id - 5'd1));
            end
         end
         OP_REPORT_ALL: begin
            mask_in  = req_mask;
            fed      = !int_blocked_ff;
            phase_in = phase_ff ^ ext_allowed_ff;
         end
         OP_INIT: ext_allowed_in = 1'b1;
         OP_FORCE_INT: begin
            int_blocked_in = 1'b1;
            phase_in       = phase_ff ^ ext_allowed_ff;
         end
         OP_FORCE_EXT: begin
            ext_allowed_in = 1'b0;
            fed            = !int_blocked_ff;
         end
         default: ;
      endcase
      all_rep     = (mask_in & req_mask) == req_mask;
      rsp_data_in = {5'd0, all_rep, captured_in, suspect_in, phase_in, fed};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff        <= '0;
         countdown_ff   <= INTERVAL_RESET;
         phase_ff       <= 1'b1;
         ext_allowed_ff <= 1'b1;
         int_blocked_ff <= 1'b0;
         captured_ff    <= '0;
         suspect_ff     <= 1'b0;
      end else if (req_acc) begin
         mask_ff        <= mask_in;
         countdown_ff   <= countdown_in;
         phase_ff       <= phase_in;
         ext_allowed_ff <= ext_allowed_in;
         int_blocked_ff <= int_blocked_in;
         captured_ff    <= captured_in;
         suspect_ff     <= suspect_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `CHK_NEXT(a_blocked_sticky, clock, reset, int_blocked_ff, int_blocked_ff)
   `CHK_NEXT(a_resp_follows, clock, reset, req_acc, rsp_tvalid)
   `CHK_NEXT(a_count_down, clock, reset,
      req_acc && op == OP_TICK && enable_ff && countdown_ff != '0,
      countdown_ff == $past(countdown_ff) - CNT_W'(1))
   `CHK_NEXT(a_check_suspect, clock, reset,
      req_acc && op == OP_TICK && enable_ff && countdown_ff == '0,
      suspect_ff && rsp_tdata[2])
   `CHK_NEXT(a_force_ext, clock, reset, req_acc && op == OP_FORCE_EXT,
      !ext_allowed_ff && rsp_tdata[1] == $past(phase_ff))

endmodule

>>> test/tb.sv
// self-checking testbench for multi_task_watchdog_supervisor_top
// keeps its own model of the check-in mask, countdown and feed state and checks every response
// depends on mtws_pkg for the opcode and register codes
module tb;
   import mtws_pkg::*;

   localparam logic [2:0] OP_SPARE6 = 3'd6;
   localparam logic [2:0] OP_SPARE7 = 3'd7;

   typedef struct packed {
      logic        all_reported;
      logic [30:0] saved_reports;
      logic        timeout_suspect;
      logic        external_level;
      logic        internal_feed;
   } feed_status_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // opcode[2:0], reporter_id[7:3]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // internal_feed[0], external_level[1], timeout_suspect[2],
                                  // saved_reports[33:3], all_reported[34], zero[39:35]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   multi_task_watchdog_supervisor_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // supervisor model state
   logic [REQ_W-1:0] req_cfg      = REQUIRED_RESET;
   logic [CNT_W-1:0] interval_cfg = INTERVAL_RESET;
   logic             enable_cfg   = ENABLE_RESET;
   mask_type         checkin      = '0;
   mask_type         saved_mask   = '0;
   logic [CNT_W-1:0] countdown    = INTERVAL_RESET;
   logic             ext_phase    = 1'b1;
   logic             ext_allowed  = 1'b1;
   logic             int_blocked  = 1'b0;
   logic             suspect      = 1'b0;

   feed_status_t pending_status[$];
   int unsigned  send_idle_pct = 0;
   int unsigned  recv_idle_pct = 0;
   int unsigned  failures = 0;
   int unsigned  items_sent = 0;
   int unsigned  checks_run = 0;
   int unsigned  checks_passed = 0;
   int unsigned  settings_seen = 0;
   bit           force_int_ok = 1'b0;

   function automatic mask_type reporters_needed();
      return mask_type'((32'd1 << req_cfg) - 32'd1);
   endfunction

   function automatic void toggle_external();
      if (ext_allowed) ext_phase = ~ext_phase;
   endfunction

   function automatic logic feed_both();
      toggle_external();
      return !int_blocked;
   endfunction

   function automatic feed_status_t supervise(logic [2:0] op, logic [4:0] id);
      mask_type     need;
      logic         fed;
      feed_status_t s;
      need = reporters_needed();
      fed = 1'b0;
      case (op)
         OP_TICK: begin
            if (!enable_cfg) begin
               fed = feed_both();
            end else if (countdown != 0) begin
               fed = feed_both();
               countdown = countdown - 1'b1;
               suspect = 1'b0;
            end else begin
               saved_mask = checkin;
               suspect = 1'b1;
               checks_run++;
               if ((checkin & need) == need) begin
                  fed = feed_both();
                  checkin = '0;
                  countdown = interval_cfg;
                  checks_passed++;
               end
            end
         end
         OP_REPORT: if (id != 5'd0) checkin[id - 5'd1] = 1'b1;
         OP_REPORT_ALL: begin
            checkin = need;
            fed = feed_both();
         end
         OP_INIT: ext_allowed = 1'b1;
         OP_FORCE_INT: begin
            int_blocked = 1'b1;
            toggle_external();
         end
         OP_FORCE_EXT: begin
            ext_allowed = 1'b0;
            fed = !int_blocked;
         end
         default: ;
      endcase
      s.internal_feed = fed;
      s.external_level = ext_phase;
      s.timeout_suspect = suspect;
      s.saved_reports = saved_mask;
      s.all_reported = ((checkin & need) == need);
      return s;
   endfunction

   // response checker and receiver stalls
   always @(posedge clock) begin : rsp_check
      feed_status_t want;
      feed_status_t got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[34:0];
         if (pending_status.size() == 0) begin
            $error("response transaction with nothing outstanding: %h", rsp_tdata);
            failures++;
         end else begin
            want = pending_status.pop_front();
            if (got.internal_feed !== want.internal_feed) begin
               $error("internal_feed: expected %0d, got %0d", want.internal_feed,
                      got.internal_feed);
               failures++;
            end
            if (got.external_level !== want.external_level) begin
               $error("external_level: expected %0d, got %0d", want.external_level,
                      got.external_level);
               failures++;
            end
            if (got.timeout_suspect !== want.timeout_suspect) begin
               $error("timeout_suspect: expected %0d, got %0d", want.timeout_suspect,
                      got.timeout_suspect);
               failures++;
            end
            if (got.saved_reports !== want.saved_reports) begin
               $error("saved_reports: expected %h, got %h", want.saved_reports,
                      got.saved_reports);
               failures++;
            end
            if (got.all_reported !== want.all_reported) begin
               $error("all_reported: expected %0d, got %0d", want.all_reported,
                      got.all_reported);
               failures++;
            end
            if (rsp_tdata[39:35] !== 5'd0) begin
               $error("padding: expected 0, got %h", rsp_tdata[39:35]);
               failures++;
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(logic [2:0] op, logic [4:0] id);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {id, op};
      do @(posedge clock); while (!req_tready);
      pending_status.push_back(supervise(op, id));
      if (op <= 3'(OP_FORCE_EXT) && !(op == OP_REPORT && id == 5'd0)) items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_REQUIRED: req_cfg = value[REQ_W-1:0];
         CSR_INTERVAL: interval_cfg = value[CNT_W-1:0];
         CSR_ENABLE:   enable_cfg = value[0];
         default: ;
      endcase
      settings_seen++;
   endtask

   function automatic logic [4:0] pick_required();
      case ($urandom_range(7))
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd2;
         3: return 5'd3;
         4: return 5'd5;
         5: return 5'd8;
         6: return 5'($urandom_range(31));
         default: return 5'd31;
      endcase
   endfunction

   task automatic noise_item();
      logic [2:0] op;
      op = 3'($urandom_range(7));
      if (op == OP_FORCE_INT && !force_int_ok) op = OP_TICK;
      send_item(op, 5'($urandom));
   endtask

   // tick until the countdown expires, then the verifying tick; with the check disabled, one to three plain ticks
   task automatic run_to_check();
      if (!enable_cfg) begin
         repeat ($urandom_range(1, 3)) send_item(OP_TICK, 5'($urandom));
      end else begin
         while (countdown != 0) send_item(OP_TICK, 5'($urandom));
         send_item(OP_TICK, 5'($urandom));
      end
   endtask

   task automatic retune();
      int unsigned pick;
      wait_drained();
      pick = $urandom_range(9);
      if (pick < 4)
         write_csr(CSR_REQUIRED, {27'($urandom), pick_required()});
      else if (pick < 8)
         write_csr(CSR_INTERVAL, {16'($urandom), 16'($urandom_range(0, pick == 7 ? 20 : 4))});
      else
         write_csr(CSR_ENABLE, {31'($urandom), 1'($urandom_range(99) >= 25)});
   endtask

   task automatic checkin_round();
      logic [4:0]  order[$];
      logic [4:0]  tmp;
      logic [4:0]  skip;
      int unsigned j;
      for (int i = 1; i <= int'(req_cfg); i++) order.push_back(5'(i));
      for (int i = order.size() - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      skip = (req_cfg != 0 && $urandom_range(4) == 0) ? 5'($urandom_range(1, req_cfg)) : 5'd0;
      if ($urandom_range(9) == 0) begin
         send_item(OP_REPORT_ALL, 5'($urandom));
      end else begin
         foreach (order[k]) begin
            if ($urandom_range(9) == 0) noise_item();
            if (order[k] != skip) send_item(OP_REPORT, order[k]);
         end
      end
      run_to_check();
   endtask

   task automatic run_rounds(int unsigned target);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < target) begin
         if ($urandom_range(3) == 0) retune();
         if ($urandom_range(9) < 2)
            repeat ($urandom_range(4, 12)) noise_item();
         else
            checkin_round();
      end
   endtask

   task automatic test_opcodes();
      send_item(OP_REPORT, 5'd0);
      send_item(OP_REPORT, 5'd1);
      send_item(OP_REPORT, 5'd31);
      send_item(OP_SPARE6, 5'd31);
      send_item(OP_SPARE7, 5'd0);
      send_item(OP_INIT, 5'd0);
      send_item(OP_FORCE_EXT, 5'd0);
      send_item(OP_TICK, 5'd31);
      send_item(OP_INIT, 5'd31);
      send_item(OP_TICK, 5'd0);
   endtask

   task automatic test_verification();
      run_to_check();
      send_item(OP_REPORT_ALL, 5'd0);
      send_item(OP_TICK, 5'd0);
      wait_drained();
      write_csr(CSR_REQUIRED, 32'hffff_ffe0);
      write_csr(CSR_INTERVAL, 32'hffff_0000);
      write_csr(CSR_ENABLE, 32'hffff_fffe);
      send_item(OP_TICK, 5'd0);
      wait_drained();
      write_csr(CSR_ENABLE, 32'd1);
      run_to_check();
   endtask

   task automatic test_random_sender_slow();
      send_idle_pct = 30;
      recv_idle_pct = 59;
      run_rounds(630);
   endtask

   task automatic test_random_receiver_slow();
      send_idle_pct = 59;
      recv_idle_pct = 30;
      run_rounds(630);
   endtask

   task automatic test_random_no_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_rounds(600);
   endtask

   task automatic test_extremes();
      force_int_ok = 1'b1;
      wait_drained();
      write_csr(CSR_REQUIRED, 32'd0);
      write_csr(CSR_INTERVAL, 32'h0000_ffff);
      write_csr(CSR_ENABLE, 32'd1);
      run_to_check();
      repeat (3) send_item(OP_TICK, 5'($urandom));
      send_item(OP_FORCE_INT, 5'd0);
      send_item(OP_TICK, 5'd0);
      send_item(OP_REPORT_ALL, 5'd0);
      repeat (20) noise_item();
      wait_drained();
      write_csr(CSR_ENABLE, 32'd0);
      repeat (3) send_item(OP_TICK, 5'($urandom));
      wait_drained();
      write_csr(CSR_REQUIRED, 32'd31);
      write_csr(CSR_ENABLE, 32'd1);
      send_item(OP_REPORT_ALL, 5'd0);
      send_item(OP_TICK, 5'd0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 30;
      recv_idle_pct = 59;
      test_opcodes();
      test_verification();
      test_random_sender_slow();
      test_random_receiver_slow();
      test_random_no_idle();
      test_extremes();
      wait_drained();
      repeat (4) @(posedge clock);
      $display("%0d requests over %0d register writes, %0d verifications (%0d passed)",
               items_sent, settings_seen, checks_run, checks_passed);
      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d responses outstanding", pending_status.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
